>>> sv/rgps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rgps_pkg
// Shared field widths and command codes for the range gradient position step.
// -----------------------------------------------------------------------------
package rgps_pkg;

   localparam int CMD_W  = 2;
   localparam int POS_W  = 32;
   localparam int DIST_W = 16;
   localparam int GRAD_W = 48;
   localparam int STEP_W = 16;
   localparam int THR_W  = 31;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_LOAD     = 2'd0;
   localparam cmd_type CMD_NEIGHBOR = 2'd1;
   localparam cmd_type CMD_FINISH   = 2'd2;

   localparam logic CSR_STEP_SIZE      = 1'b0;
   localparam logic CSR_STOP_THRESHOLD = 1'b1;

endpackage : rgps_pkg
`default_nettype wire

>>> sv/rgps_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rgps_if
// Valid/ready channels for request items and result items.
// -----------------------------------------------------------------------------
interface rgps_req_if import rgps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   cmd_type                  cmd;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic [DIST_W-1:0]        measured_distance;

   modport source (output valid, cmd, pos_x, pos_y, measured_distance, input ready);
   modport sink   (input valid, cmd, pos_x, pos_y, measured_distance, output ready);
endinterface : rgps_req_if

interface rgps_rsp_if import rgps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  new_x;
   logic signed [POS_W-1:0]  new_y;
   logic                     converged;

   modport source (output valid, new_x, new_y, converged, input ready);
   modport sink   (input valid, new_x, new_y, converged, output ready);
endinterface : rgps_rsp_if
`default_nettype wire

>>> sv/range_gradient_position_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// range_gradient_position_step_unit
// Gradient-descent position update for range based localization, bit serial.
// -----------------------------------------------------------------------------
// Load: estimate and cleared gradient registered on the transfer. Neighbor
// term: shift-add squares, bit-serial root, shift-add product, restoring
// divide, then gradient accumulate. Finish: shift-add gain multiply, then
// result valid once the output register is free. One item at a time; ready only when idle.
// Synchronous active-high reset clears estimate, gradient, control; loads step/threshold defaults.
// -----------------------------------------------------------------------------
module range_gradient_position_step_unit
   import rgps_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   rgps_req_if.sink           req,
   rgps_rsp_if.source         rsp,
   input  wire                csr_we,
   input  wire                csr_index,
   input  wire [THR_W-1:0]    csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQR   = 4'd1;
   localparam logic [3:0] ST_SQSUM = 4'd2;
   localparam logic [3:0] ST_ROOT  = 4'd3;
   localparam logic [3:0] ST_DIFF  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_DIVI  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_ACC   = 4'd8;
   localparam logic [3:0] ST_FMUL  = 4'd9;
   localparam logic [3:0] ST_FUPD  = 4'd10;

   localparam logic [31:0] ONE_FIXED = 32'd1 << FRAC_BITS;
   localparam int          R_SHIFT   = FRAC_BITS - 8;

   logic [3:0]        state_ff, state_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [31:0]       est_ff [2], est_in [2];
   logic [47:0]       grad_ff [2], grad_in [2];
   logic [31:0]       dmag_ff [2], dmag_in [2];
   logic              dneg_ff [2], dneg_in [2];
   logic [63:0]       mul_a_ff [2], mul_a_in [2];
   logic [31:0]       mul_b_ff [2], mul_b_in [2];
   logic [63:0]       mul_p_ff [2], mul_p_in [2];
   logic [32:0]       rem_ff [2], rem_in [2];
   logic [33:0]       quo_ff [2], quo_in [2];
   logic [63:0]       rt_n_ff, rt_n_in;
   logic [63:0]       rt_res_ff, rt_res_in;
   logic [63:0]       rt_bit_ff, rt_bit_in;
   logic [31:0]       len_ff, len_in;
   logic              diffneg_ff, diffneg_in;
   logic [DIST_W-1:0] meas_ff, meas_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_x_ff, rsp_x_in;
   logic [31:0]       rsp_y_ff, rsp_y_in;
   logic              rsp_conv_ff, rsp_conv_in;

   logic req_xfer;
   logic out_free;

   assign req.ready     = (state_ff == ST_IDLE);
   assign req_xfer      = req.valid && req.ready;
   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.new_x     = rsp_x_ff;
   assign rsp.new_y     = rsp_y_ff;
   assign rsp.converged = rsp_conv_ff;

   always_comb begin
      logic [31:0] pos [2];
      logic [32:0] dw [2];
      logic [31:0] ds [2];
      logic [31:0] dv [2];
      logic        dzero;
      logic [63:0] t;
      logic        ge;
      logic [31:0] r;
      logic [33:0] diff;
      logic [32:0] rsh;
      logic        tneg;
      logic [48:0] term;
      logic [48:0] gsum;
      logic [47:0] gmag;
      logic [48:0] smove;
      logic [48:0] nx49;
      logic [31:0] nx [2];
      logic [32:0] dl;
      logic [32:0] mv [2];

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      thr_in       = thr_ff;
      est_in       = est_ff;
      grad_in      = grad_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_p_in     = mul_p_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rt_n_in      = rt_n_ff;
      rt_res_in    = rt_res_ff;
      rt_bit_in    = rt_bit_ff;
      len_in       = len_ff;
      diffneg_in   = diffneg_ff;
      meas_in      = meas_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_conv_in  = rsp_conv_ff;

      rsh   = '0;
      tneg  = 1'b0;
      term  = '0;
      gsum  = '0;
      gmag  = '0;
      smove = '0;
      nx49  = '0;
      dl    = '0;
      for (int i = 0; i < 2; i++) begin
         nx[i] = '0;
         mv[i] = '0;
      end

      pos[0] = req.pos_x;
      pos[1] = req.pos_y;
      for (int i = 0; i < 2; i++) begin
         dw[i] = {est_ff[i][31], est_ff[i]} - {pos[i][31], pos[i]};
         if (dw[i][32] != dw[i][31]) begin
            ds[i] = dw[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            ds[i] = dw[i][31:0];
         end
      end
      dzero = (ds[0] == 32'd0) && (ds[1] == 32'd0);
      for (int i = 0; i < 2; i++) begin
         dv[i] = dzero ? ONE_FIXED : ds[i];
      end

      t  = rt_res_ff + rt_bit_ff;
      ge = (rt_n_ff >= t);

      r    = {16'd0, meas_ff} << R_SHIFT;
      diff = {2'b00, rt_res_ff[31:0]} - {2'b00, r};

      if (csr_we) begin
         case (csr_index)
            CSR_STEP_SIZE:      step_in = csr_wdata[STEP_W-1:0];
            CSR_STOP_THRESHOLD: thr_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req.cmd)
                  CMD_LOAD: begin
                     est_in[0]  = req.pos_x;
                     est_in[1]  = req.pos_y;
                     grad_in[0] = '0;
                     grad_in[1] = '0;
                  end
                  CMD_NEIGHBOR: begin
                     for (int i = 0; i < 2; i++) begin
                        dneg_in[i]  = dv[i][31];
                        dmag_in[i]  = dv[i][31] ? (32'd0 - dv[i]) : dv[i];
                        mul_a_in[i] = {32'd0, dmag_in[i]};
                        mul_b_in[i] = dmag_in[i];
                        mul_p_in[i] = '0;
                     end
                     meas_in  = req.measured_distance;
                     cnt_in   = '0;
                     state_in = ST_SQR;
                  end
                  CMD_FINISH: begin
                     for (int i = 0; i < 2; i++) begin
                        gmag        = grad_ff[i][47] ? (48'd0 - grad_ff[i]) : grad_ff[i];
                        mul_a_in[i] = {16'd0, gmag};
                        mul_b_in[i] = {16'd0, step_ff};
                        mul_p_in[i] = '0;
                     end
                     cnt_in   = '0;
                     state_in = ST_FMUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_SQR, ST_MUL, ST_FMUL: begin
            // one multiplier bit per cycle
            for (int i = 0; i < 2; i++) begin
               mul_p_in[i] = mul_p_ff[i] + (mul_b_ff[i][0] ? mul_a_ff[i] : 64'd0);
               mul_a_in[i] = {mul_a_ff[i][62:0], 1'b0};
               mul_b_in[i] = {1'b0, mul_b_ff[i][31:1]};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               case (state_ff)
                  ST_SQR:  state_in = ST_SQSUM;
                  ST_MUL:  state_in = ST_DIVI;
                  default: state_in = ST_FUPD;
               endcase
            end
         end
         ST_SQSUM: begin
            rt_n_in   = mul_p_ff[0] + mul_p_ff[1];
            rt_res_in = '0;
            rt_bit_in = 64'd1 << 62;
            cnt_in    = '0;
            state_in  = ST_ROOT;
         end
         ST_ROOT: begin
            // one root bit per cycle
            rt_n_in   = ge ? (rt_n_ff - t) : rt_n_ff;
            rt_res_in = ge ? ((rt_res_ff >> 1) + rt_bit_ff) : (rt_res_ff >> 1);
            rt_bit_in = rt_bit_ff >> 2;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            len_in     = rt_res_ff[31:0];
            diffneg_in = diff[33];
            for (int i = 0; i < 2; i++) begin
               mul_a_in[i] = {30'd0, (diff[33] ? (34'd0 - diff) : diff)};
               mul_b_in[i] = dmag_ff[i];
               mul_p_in[i] = '0;
            end
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_DIVI: begin
            for (int i = 0; i < 2; i++) begin
               rem_in[i] = '0;
               quo_in[i] = '0;
            end
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, numerator shifts out of the product register
            for (int i = 0; i < 2; i++) begin
               rsh = {rem_ff[i][31:0], mul_p_ff[i][63]};
               if (rsh >= {1'b0, len_ff}) begin
                  rem_in[i] = rsh - {1'b0, len_ff};
                  quo_in[i] = {quo_ff[i][32:0], 1'b1};
               end else begin
                  rem_in[i] = rsh;
                  quo_in[i] = {quo_ff[i][32:0], 1'b0};
               end
               mul_p_in[i] = {mul_p_ff[i][62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            for (int i = 0; i < 2; i++) begin
               tneg = dneg_ff[i] ^ diffneg_ff;
               term = tneg ? (49'd0 - {15'd0, quo_ff[i]}) : {15'd0, quo_ff[i]};
               gsum = {grad_ff[i][47], grad_ff[i]} + term;
               if (gsum[48] != gsum[47]) begin
                  grad_in[i] = gsum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               end else begin
                  grad_in[i] = gsum[47:0];
               end
            end
            state_in = ST_IDLE;
         end
         ST_FUPD: begin
            for (int i = 0; i < 2; i++) begin
               smove = {1'b0, mul_p_ff[i][63:16]};
               if (grad_ff[i][47]) begin
                  smove = 49'd0 - smove;
               end
               nx49 = {{17{est_ff[i][31]}}, est_ff[i]} - smove;
               if (nx49[48:31] != {18{1'b0}} && nx49[48:31] != {18{1'b1}}) begin
                  nx[i] = nx49[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  nx[i] = nx49[31:0];
               end
               dl    = {nx[i][31], nx[i]} - {est_ff[i][31], est_ff[i]};
               mv[i] = dl[32] ? (33'd0 - dl) : dl;
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = nx[0];
               rsp_y_in     = nx[1];
               rsp_conv_in  = (mv[0] < {2'b00, thr_ff}) && (mv[1] < {2'b00, thr_ff});
               est_in[0]    = nx[0];
               est_in[1]    = nx[1];
               grad_in[0]   = '0;
               grad_in[1]   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= STEP_W'(6554);
         thr_ff       <= THR_W'(65536);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            est_ff[i]  <= '0;
            grad_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 2; i++) begin
            est_ff[i]  <= est_in[i];
            grad_ff[i] <= grad_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         dmag_ff[i]  <= dmag_in[i];
         dneg_ff[i]  <= dneg_in[i];
         mul_a_ff[i] <= mul_a_in[i];
         mul_b_ff[i] <= mul_b_in[i];
         mul_p_ff[i] <= mul_p_in[i];
         rem_ff[i]   <= rem_in[i];
         quo_ff[i]   <= quo_in[i];
      end
      rt_n_ff     <= rt_n_in;
      rt_res_ff   <= rt_res_in;
      rt_bit_ff   <= rt_bit_in;
      len_ff      <= len_in;
      diffneg_ff  <= diffneg_in;
      meas_ff     <= meas_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_conv_ff <= rsp_conv_in;
   end

endmodule : range_gradient_position_step_unit
`default_nettype wire
